// ===== rtl/ssc_pkg.sv =====
package ssc_pkg;

    localparam int POS_W           = 31;
    localparam int PROB_W          = 16;
    localparam int PROB_BITS_DEF   = 16;
    localparam int TH_W            = 16;
    localparam logic [TH_W-1:0] TH_RESET = 16'd32768;

    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 64;
    localparam int PADDR_W   = 3;

    localparam logic REG_PROB_THRESHOLD = 1'b0;

    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic [PROB_W-1:0] prob_left;
        logic [PROB_W-1:0] prob_none;
        logic [PROB_W-1:0] prob_right;
        logic [PROB_W-1:0] prob_stall;
        logic              first_of_read;
        logic              last_of_read;
    } item_t;

    typedef struct packed {
        logic              in_stall;
        logic [POS_W-1:0]  open_start;
        logic [POS_W-1:0]  pending_end;
        logic              pending_end_valid;
    } seg_state_t;

    typedef struct packed {
        logic              emit;
        logic [POS_W-1:0]  stall_start;
        logic [POS_W-1:0]  stall_end;
        logic              at_read_end;
    } seg_result_t;

endpackage

// ===== rtl/stall_segment_caller.sv =====
// Pipeline: input register, then result register.
// Throughput: one request per cycle unless the master side stalls; a request yields zero or one result.
// Backpressure on the master side stalls the input register only when the result register is full.
// Reset (rst_n low, asynchronous): threshold 32768, no open stall, previous stall probability 0,
// both pipeline registers empty.
module stall_segment_caller
    import ssc_pkg::*;
#(
    parameter int PROB_BITS = PROB_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // position[30:0], prob_left[46:31], prob_none[62:47], prob_right[78:63],
    // prob_stall[94:79], zero[95]
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // first_of_read[0]
    input  logic                 s_axis_tuser,
    input  logic                 s_axis_tlast,

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // stall_start[30:0], stall_end[61:31], zero[63:62]
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // at_read_end[0]
    output logic                 m_axis_tuser,

    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int PW = (PROB_BITS < PROB_W) ? PROB_BITS : PROB_W;

    logic [TH_W-1:0] prob_threshold_reg;

    logic            in_valid_reg;
    item_t           in_item_reg;

    seg_state_t      state_reg;
    seg_state_t      state_next;
    logic [PW-1:0]   prev_stall_prob_reg;
    logic [PW-1:0]   prev_stall_prob_next;
    seg_result_t     result;

    logic            out_valid_reg;
    logic [POS_W-1:0] out_start_reg;
    logic [POS_W-1:0] out_end_reg;
    logic            out_flush_reg;

    logic            advance;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_PROB_THRESHOLD) ? 32'(prob_threshold_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prob_threshold_reg <= TH_RESET;
        else if (psel && penable && pwrite && pready && paddr[2] == REG_PROB_THRESHOLD)
            prob_threshold_reg <= pwdata[TH_W-1:0];
    end

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg.position      <= s_axis_tdata[30:0];
            in_item_reg.prob_left     <= s_axis_tdata[46:31];
            in_item_reg.prob_none     <= s_axis_tdata[62:47];
            in_item_reg.prob_right    <= s_axis_tdata[78:63];
            in_item_reg.prob_stall    <= s_axis_tdata[94:79];
            in_item_reg.first_of_read <= s_axis_tuser;
            in_item_reg.last_of_read  <= s_axis_tlast;
        end
    end

    ssc_decide #(
        .PROB_BITS (PROB_BITS)
    ) u_decide (
        .item                 (in_item_reg),
        .state                (state_reg),
        .prev_stall_prob      (prev_stall_prob_reg),
        .prob_threshold       (prob_threshold_reg),
        .state_next           (state_next),
        .prev_stall_prob_next (prev_stall_prob_next),
        .result               (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= '0;
            prev_stall_prob_reg <= '0;
        end
        else if (in_valid_reg && advance)
        begin
            state_reg           <= state_next;
            prev_stall_prob_reg <= prev_stall_prob_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg && result.emit;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg && result.emit)
        begin
            out_start_reg <= result.stall_start;
            out_end_reg   <= result.stall_end;
            out_flush_reg <= result.at_read_end;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_end_reg, out_start_reg};
    assign m_axis_tuser  = out_flush_reg;

endmodule

// ===== rtl/ssc_decide.sv =====
module ssc_decide
    import ssc_pkg::*;
#(
    parameter int PROB_BITS = PROB_BITS_DEF,
    localparam int PW = (PROB_BITS < PROB_W) ? PROB_BITS : PROB_W
)
(
    input  item_t             item,
    input  seg_state_t        state,
    input  logic [PW-1:0]     prev_stall_prob,
    input  logic [TH_W-1:0]   prob_threshold,
    output seg_state_t        state_next,
    output logic [PW-1:0]     prev_stall_prob_next,
    output seg_result_t       result
);

    logic [PW-1:0]   pl_m;
    logic [PW-1:0]   pn_m;
    logic [PW-1:0]   pr_m;
    logic [PW-1:0]   ps_m;
    logic [TH_W-1:0] pl;
    logic [TH_W-1:0] pn;
    logic [TH_W-1:0] pr;
    logic [TH_W-1:0] ps;
    logic [TH_W-1:0] prev;
    seg_state_t      mid;

    assign pl_m = PW'(item.prob_left);
    assign pn_m = PW'(item.prob_none);
    assign pr_m = PW'(item.prob_right);
    assign ps_m = PW'(item.prob_stall);
    assign pl   = TH_W'(pl_m);
    assign pn   = TH_W'(pn_m);
    assign pr   = TH_W'(pr_m);
    assign ps   = TH_W'(ps_m);
    assign prev = TH_W'(prev_stall_prob);

    assign prev_stall_prob_next = ps_m;

    always_comb
    begin
        mid    = state;
        result = '0;
        if (item.first_of_read)
        begin
            mid = '0;
        end
        else if (ps > prob_threshold && !state.in_stall)
        begin
            mid.open_start = item.position;
            mid.in_stall   = 1'b1;
        end
        else if (state.in_stall && ps < prob_threshold && prev > prob_threshold)
        begin
            mid.pending_end       = item.position;
            mid.pending_end_valid = 1'b1;
        end
        else if (state.in_stall && (pl > prob_threshold || pn > prob_threshold
                                    || pr > prob_threshold))
        begin
            result.emit        = 1'b1;
            result.stall_start = state.open_start;
            result.stall_end   = state.pending_end_valid ? state.pending_end : item.position;
            result.at_read_end = 1'b0;
            mid                = '0;
        end

        state_next = mid;
        // end-of-read flush of a stall still open
        if (item.last_of_read && mid.in_stall)
        begin
            result.emit        = 1'b1;
            result.stall_start = mid.open_start;
            result.stall_end   = mid.pending_end_valid ? mid.pending_end : item.position;
            result.at_read_end = 1'b1;
            state_next         = '0;
        end
    end

endmodule

// ===== tb/tb_stall_segment_caller.sv =====
module tb_stall_segment_caller
    import ssc_pkg::*;
();

    localparam int CYCLE_LIMIT    = 400000;
    localparam int RX_HOLD_CYCLES = 60;
    localparam int PIPE_SLACK     = 8;
    localparam int IDLE_PCT       = 8;

    localparam logic [PADDR_W-1:0] TH_ADDR    = PADDR_W'(4 * int'(REG_PROB_THRESHOLD));
    localparam logic [PADDR_W-1:0] SPARE_ADDR = PADDR_W'(4 * (int'(REG_PROB_THRESHOLD) + 1));

    localparam logic [PROB_W-1:0] PF      = 16'hFFFF;
    localparam logic [PROB_W-1:0] P0      = 16'd0;
    localparam logic [POS_W-1:0]  POS_MAX = 31'h7FFFFFFF;

    typedef struct packed {
        logic [POS_W-1:0] seg_start;
        logic [POS_W-1:0] seg_end;
        logic             flushed;
    } seg_t;

    typedef enum logic [1:0] {BY_MODEL, NO_SEG, SEG_OUT} row_how_e;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [PROB_W-1:0] pl;
        logic [PROB_W-1:0] pn;
        logic [PROB_W-1:0] pr;
        logic [PROB_W-1:0] ps;
        logic              first;
        logic              last;
        row_how_e          how;
        logic [POS_W-1:0]  exp_start;
        logic [POS_W-1:0]  exp_stop;
        logic              exp_flush;
    } row_t;

    // threshold at reset value (0.5)
    localparam row_t DIRECTED [22] = '{
        '{31'd7,   P0, P0, P0, PF,          1'b0, 1'b0, NO_SEG,   31'd0,   31'd0,   1'b0},
        '{31'd9,   P0, PF, P0, P0,          1'b0, 1'b0, BY_MODEL, 31'd0,   31'd0,   1'b0},
        '{31'd10,  P0, PF, P0, P0,          1'b0, 1'b0, SEG_OUT,  31'd7,   31'd9,   1'b0},
        '{31'd13,  P0, P0, P0, 16'd40000,   1'b0, 1'b0, BY_MODEL, 31'd0,   31'd0,   1'b0},
        '{31'd14,  P0, 16'd40000, P0, 16'd40000,
                                            1'b0, 1'b0, SEG_OUT,  31'd13,  31'd14,  1'b0},
        '{31'd15,  P0, P0, P0, 16'd32768,   1'b0, 1'b0, BY_MODEL, 31'd0,   31'd0,   1'b0},
        '{31'd16,  P0, P0, P0, 16'd32769,   1'b0, 1'b0, BY_MODEL, 31'd0,   31'd0,   1'b0},
        '{31'd17,  P0, P0, P0, 16'd32767,   1'b0, 1'b0, BY_MODEL, 31'd0,   31'd0,   1'b0},
        '{31'd18,  16'd32768, P0, P0, PF,   1'b0, 1'b0, BY_MODEL, 31'd0,   31'd0,   1'b0},
        '{31'd19,  P0, P0, P0, 16'd100,     1'b0, 1'b0, BY_MODEL, 31'd0,   31'd0,   1'b0},
        '{31'd20,  P0, P0, PF, P0,          1'b0, 1'b1, SEG_OUT,  31'd16,  31'd19,  1'b0},
        '{POS_MAX, PF, PF, PF, PF,          1'b1, 1'b0, NO_SEG,   31'd0,   31'd0,   1'b0},
        '{POS_MAX, P0, P0, P0, PF,          1'b0, 1'b0, BY_MODEL, 31'd0,   31'd0,   1'b0},
        '{31'd5,   P0, P0, P0, P0,          1'b0, 1'b1, SEG_OUT,  POS_MAX, 31'd5,   1'b1},
        '{31'd100, P0, P0, P0, P0,          1'b1, 1'b0, NO_SEG,   31'd0,   31'd0,   1'b0},
        '{31'd101, PF, PF, PF, 16'd50000,   1'b0, 1'b0, BY_MODEL, 31'd0,   31'd0,   1'b0},
        '{31'd102, P0, P0, P0, 16'd50000,   1'b0, 1'b1, SEG_OUT,  31'd101, 31'd102, 1'b1},
        '{31'd200, P0, P0, P0, PF,          1'b1, 1'b1, NO_SEG,   31'd0,   31'd0,   1'b0},
        '{31'd201, P0, P0, P0, PF,          1'b0, 1'b0, BY_MODEL, 31'd0,   31'd0,   1'b0},
        '{31'd202, P0, P0, P0, PF,          1'b1, 1'b1, NO_SEG,   31'd0,   31'd0,   1'b0},
        '{31'd203, P0, P0, P0, PF,          1'b0, 1'b1, SEG_OUT,  31'd203, 31'd203, 1'b1},
        '{31'd0,   P0, P0, P0, P0,          1'b0, 1'b1, NO_SEG,   31'd0,   31'd0,   1'b0}
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 s_axis_tuser = 1'b0;
    logic                 s_axis_tlast = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tuser;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    stall_segment_caller dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // segment tracker mirror
    logic [PROB_W-1:0] th_now = TH_RESET;
    logic              trk_in_stall = 1'b0;
    logic [POS_W-1:0]  trk_open = '0;
    logic [POS_W-1:0]  trk_pend = '0;
    logic              trk_pend_ok = 1'b0;
    logic [PROB_W-1:0] trk_prev_ps = '0;

    seg_t seg_expected [$];
    int   errors = 0;
    int   cycles = 0;
    bit   idle_on = 1'b1;
    int   rx_holds_asked = 0;
    int   rx_holds_done = 0;

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic seg_t close_segment(input logic [POS_W-1:0] pos, input logic flush);
        seg_t seg;
        seg.seg_start = trk_open;
        seg.seg_end   = trk_pend_ok ? trk_pend : pos;
        seg.flushed   = flush;
        trk_in_stall = 1'b0;
        trk_open     = '0;
        trk_pend     = '0;
        trk_pend_ok  = 1'b0;
        return seg;
    endfunction

    function automatic void expect_segment(input seg_t seg);
        seg_expected = {seg_expected, seg};
    endfunction

    function automatic bit call_segment(input item_t it, output seg_t seg);
        bit hit;
        hit = 1'b0;
        seg = '0;
        if (it.first_of_read)
        begin
            trk_in_stall = 1'b0;
            trk_open     = '0;
            trk_pend     = '0;
            trk_pend_ok  = 1'b0;
        end
        else if (it.prob_stall > th_now && !trk_in_stall)
        begin
            trk_open     = it.position;
            trk_in_stall = 1'b1;
        end
        else if (trk_in_stall && it.prob_stall < th_now && trk_prev_ps > th_now)
        begin
            trk_pend    = it.position;
            trk_pend_ok = 1'b1;
        end
        else if (trk_in_stall && (it.prob_left > th_now || it.prob_none > th_now
                                  || it.prob_right > th_now))
        begin
            seg = close_segment(it.position, 1'b0);
            hit = 1'b1;
        end
        trk_prev_ps = it.prob_stall;
        if (it.last_of_read && trk_in_stall)
        begin
            seg = close_segment(it.position, 1'b1);
            hit = 1'b1;
        end
        return hit;
    endfunction

    task automatic send_item(input item_t it, input row_how_e how, input seg_t typed);
        seg_t seg;
        bit   hit;
        while (idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, it.prob_stall, it.prob_right, it.prob_none, it.prob_left,
                          it.position};
        s_axis_tuser  <= it.first_of_read;
        s_axis_tlast  <= it.last_of_read;
        do @(posedge clk); while (!s_axis_tready);
        hit = call_segment(it, seg);
        case (how)
            BY_MODEL: if (hit) expect_segment(seg);
            SEG_OUT:  expect_segment(typed);
            default:  ;
        endcase
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (seg_expected.size() != 0) @(posedge clk);
        repeat (PIPE_SLACK) @(posedge clk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == TH_ADDR)
            th_now = data[PROB_W-1:0];
    endtask

    // equal to threshold now and then, otherwise strictly above or below (threshold itself at the 0 / FFFF ends)
    function automatic logic [PROB_W-1:0] prob_level(input bit above);
        if ($urandom_range(15) == 0)
            return th_now;
        if (above)
            return (th_now == PF) ? PF : PROB_W'($urandom_range(65535, int'(th_now) + 1));
        return (th_now == P0) ? P0 : PROB_W'($urandom_range(int'(th_now) - 1, 0));
    endfunction

    task automatic run_reads(input int n);
        int               sent;
        int               len;
        int               kind;
        int               fork_cls;
        logic [POS_W-1:0] pos;
        item_t            it;
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(9) == 0)
            begin
                // stray request outside a well-formed read
                it.position      = POS_W'($urandom);
                it.prob_left     = PROB_W'($urandom);
                it.prob_none     = PROB_W'($urandom);
                it.prob_right    = PROB_W'($urandom);
                it.prob_stall    = PROB_W'($urandom);
                it.first_of_read = ($urandom_range(3) == 0);
                it.last_of_read  = ($urandom_range(3) == 0);
                send_item(it, BY_MODEL, '0);
                sent++;
            end
            else
            begin
                len = $urandom_range(24, 1);
                pos = POS_W'($urandom);
                for (int k = 0; k < len; k++)
                begin
                    kind = $urandom_range(99);
                    it.position      = pos;
                    it.first_of_read = (k == 0);
                    it.last_of_read  = (k == len - 1);
                    it.prob_left     = prob_level(1'b0);
                    it.prob_none     = prob_level(1'b0);
                    it.prob_right    = prob_level(1'b0);
                    if (kind < 35)
                        it.prob_stall = prob_level(1'b1);
                    else if (kind < 60)
                        it.prob_stall = prob_level(1'b0);
                    else if (kind < 85)
                    begin
                        it.prob_stall = prob_level(1'b0);
                        fork_cls = $urandom_range(2);
                        case (fork_cls)
                            0:       it.prob_left  = prob_level(1'b1);
                            1:       it.prob_none  = prob_level(1'b1);
                            default: it.prob_right = prob_level(1'b1);
                        endcase
                    end
                    else
                    begin
                        it.prob_left  = PROB_W'($urandom);
                        it.prob_none  = PROB_W'($urandom);
                        it.prob_right = PROB_W'($urandom);
                        it.prob_stall = PROB_W'($urandom);
                    end
                    send_item(it, BY_MODEL, '0);
                    pos = pos + POS_W'($urandom_range(64, 1));
                end
                sent += len;
            end
        end
    endtask

    // receiver: random idling, or a long counted hold-off when asked
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rx_holds_done != rx_holds_asked)
            begin
                rx_holds_done = rx_holds_asked;
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
            end
            m_axis_tready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        seg_t got;
        seg_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.seg_start = m_axis_tdata[POS_W-1:0];
            got.seg_end   = m_axis_tdata[2*POS_W-1:POS_W];
            got.flushed   = m_axis_tuser;
            if (seg_expected.size() == 0)
            begin
                if (errors < 10)
                    $display("unexpected segment: start %0d end %0d read_end %0b",
                             got.seg_start, got.seg_end, got.flushed);
                errors++;
            end
            else
            begin
                want = seg_expected.pop_front();
                if (got.seg_start !== want.seg_start || got.seg_end !== want.seg_end
                    || got.flushed !== want.flushed)
                begin
                    if (errors < 10)
                        $display("segment mismatch: exp %0d/%0d/%0b got %0d/%0d/%0b",
                                 want.seg_start, want.seg_end, want.flushed,
                                 got.seg_start, got.seg_end, got.flushed);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        item_t it;
        seg_t  typed;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
        begin
            it.position      = DIRECTED[i].pos;
            it.prob_left     = DIRECTED[i].pl;
            it.prob_none     = DIRECTED[i].pn;
            it.prob_right    = DIRECTED[i].pr;
            it.prob_stall    = DIRECTED[i].ps;
            it.first_of_read = DIRECTED[i].first;
            it.last_of_read  = DIRECTED[i].last;
            typed.seg_start  = DIRECTED[i].exp_start;
            typed.seg_end    = DIRECTED[i].exp_stop;
            typed.flushed    = DIRECTED[i].exp_flush;
            send_item(it, DIRECTED[i].how, typed);
        end
        drain();

        apb_write(TH_ADDR, 32'($urandom_range(65534, 1)));
        rx_holds_asked++;
        run_reads(200);
        drain();

        // unmapped register must leave the threshold alone
        apb_write(SPARE_ADDR, 32'd1000);
        apb_write(TH_ADDR, 32'd0);
        run_reads(200);
        drain();

        apb_write(TH_ADDR, 32'hFFFF);
        run_reads(150);
        drain();

        idle_on = 1'b0;
        apb_write(TH_ADDR, 32'd32768);
        run_reads(250);
        drain();

        idle_on = 1'b1;
        apb_write(TH_ADDR, 32'($urandom_range(65535)));
        run_reads(200);
        drain();
        rx_holds_asked++;
        run_reads(200);
        drain();

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
